FILE: sv/prtm_pkg.sv
// ----------------------------------------------------------------------------
// prtm_pkg
// Shared widths, constants, microcode word layout and step addresses for the
// transition matrix element unit.
// ----------------------------------------------------------------------------
package prtm_pkg;

  localparam int Q_W               = 17;
  localparam int NODE_W            = 5;
  localparam int IDX_IN_W          = 4;
  localparam int CFG_IDX_W         = 1;
  localparam int CFG_DATA_W        = 17;
  localparam int STEP_W            = 5;
  localparam int MAX_NODES_DEFAULT = 16;

  localparam logic [Q_W-1:0]    ONE_Q16          = 17'h10000;
  localparam logic [Q_W-1:0]    DAMPING_RESET    = 17'd55706;
  localparam logic [NODE_W-1:0] NODE_COUNT_RESET = 5'd16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DAMPING    = 1'b0,
    CFG_NODE_COUNT = 1'b1
  } cfg_reg_t;

  typedef enum logic [0:0] {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    DIV_RESIDUAL = 2'd0,
    DIV_LINK     = 2'd1,
    DIV_UNIFORM  = 2'd2
  } div_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD = 2'd0,
    ACC_ZERO = 2'd1,
    ACC_LOAD = 2'd2,
    ACC_ADD  = 2'd3
  } acc_op_t;

  typedef enum logic [3:0] {
    COND_NEVER     = 4'd0,
    COND_ALWAYS    = 4'd1,
    COND_NO_ITEM   = 4'd2,
    COND_WRITE     = 4'd3,
    COND_OUTSIDE   = 4'd4,
    COND_CNT_ZERO  = 4'd5,
    COND_DIV_BUSY  = 4'd6,
    COND_BIT_CLEAR = 4'd7,
    COND_OUT_FULL  = 4'd8
  } cond_t;

  localparam logic [STEP_W-1:0] STEP_IDLE      = 5'd0;
  localparam logic [STEP_W-1:0] STEP_FETCH     = 5'd1;
  localparam logic [STEP_W-1:0] STEP_RANGE     = 5'd2;
  localparam logic [STEP_W-1:0] STEP_EMPTY     = 5'd3;
  localparam logic [STEP_W-1:0] STEP_RES_GO    = 5'd4;
  localparam logic [STEP_W-1:0] STEP_RES_WAIT  = 5'd5;
  localparam logic [STEP_W-1:0] STEP_RES_TAKE  = 5'd6;
  localparam logic [STEP_W-1:0] STEP_LINK_GO   = 5'd7;
  localparam logic [STEP_W-1:0] STEP_LINK_WAIT = 5'd8;
  localparam logic [STEP_W-1:0] STEP_LINK_ADD  = 5'd9;
  localparam logic [STEP_W-1:0] STEP_UNI_GO    = 5'd10;
  localparam logic [STEP_W-1:0] STEP_UNI_WAIT  = 5'd11;
  localparam logic [STEP_W-1:0] STEP_UNI_TAKE  = 5'd12;
  localparam logic [STEP_W-1:0] STEP_ZERO      = 5'd13;
  localparam logic [STEP_W-1:0] STEP_EMIT      = 5'd14;
  localparam logic [STEP_W-1:0] STEP_DONE      = 5'd15;
  localparam logic [STEP_W-1:0] STEP_WR_CHECK  = 5'd16;
  localparam logic [STEP_W-1:0] STEP_UPDATE    = 5'd17;

  typedef struct packed {
    logic              ready_en;
    logic              fetch;
    logic              update;
    logic              div_start;
    div_sel_t          div_sel;
    acc_op_t           acc_op;
    logic              emit;
    cond_t             cond;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic no_item;
    logic write_op;
    logic outside;
    logic cnt_zero;
    logic div_busy;
    logic bit_clear;
    logic out_full;
  } status_t;

endpackage

FILE: sv/prtm_req_if.sv
// ----------------------------------------------------------------------------
// prtm_req_if
// Input channel: one link write or element read per item.
// ----------------------------------------------------------------------------
interface prtm_req_if;
  logic                          valid;
  logic                          ready;
  logic                          operation;
  logic [prtm_pkg::IDX_IN_W-1:0] row;
  logic [prtm_pkg::IDX_IN_W-1:0] column;
  logic                          link_bit;

  modport source (output valid, operation, row, column, link_bit, input ready);
  modport sink   (input valid, operation, row, column, link_bit, output ready);
endinterface

FILE: sv/prtm_rsp_if.sv
// ----------------------------------------------------------------------------
// prtm_rsp_if
// Output channel: one transition matrix element per read item.
// ----------------------------------------------------------------------------
interface prtm_rsp_if;
  logic                     valid;
  logic                     ready;
  logic [prtm_pkg::Q_W-1:0] probability;

  modport source (output valid, probability, input ready);
  modport sink   (input valid, probability, output ready);
endinterface

FILE: sv/prtm_divider.sv
// ----------------------------------------------------------------------------
// prtm_divider
// Restoring divider, one quotient bit per cycle, shared by all quotients of
// an element.
// ----------------------------------------------------------------------------
module prtm_divider #(
  parameter int DEN_W = prtm_pkg::NODE_W
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [prtm_pkg::Q_W-1:0] num,
  input  logic [DEN_W-1:0]         den,
  output logic                     busy,
  output logic [prtm_pkg::Q_W-1:0] quotient
);

  localparam int CNT_W = $clog2(prtm_pkg::Q_W + 1);

  logic [prtm_pkg::Q_W-1:0] quo;
  logic [DEN_W-1:0]         rem;
  logic [DEN_W-1:0]         divisor;
  logic [CNT_W-1:0]         count;
  logic [DEN_W:0]           trial;
  logic                     fits;

  assign trial    = {rem, quo[prtm_pkg::Q_W-1]};
  assign fits     = trial >= {1'b0, divisor};
  assign busy     = count != '0;
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (start) begin
      count <= CNT_W'(prtm_pkg::Q_W);
    end else if (busy) begin
      count <= count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo     <= num;
      rem     <= '0;
      divisor <= den;
    end else if (busy) begin
      quo <= {quo[prtm_pkg::Q_W-2:0], fits};
      if (fits) begin
        rem <= DEN_W'(trial - {1'b0, divisor});
      end else begin
        rem <= trial[DEN_W-1:0];
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) start |=> busy)
    else $error("divider did not start");

endmodule

FILE: sv/prtm_sequencer.sv
// ----------------------------------------------------------------------------
// prtm_sequencer
// Step counter and microcode rom; each step issues one control word and may
// jump on one datapath condition.
// ----------------------------------------------------------------------------
module prtm_sequencer (
  input  logic              clk,
  input  logic              rst,
  input  prtm_pkg::status_t status,
  output prtm_pkg::ctrl_t   ctrl
);

  function automatic prtm_pkg::ctrl_t rom_word(input logic [prtm_pkg::STEP_W-1:0] step);
    prtm_pkg::ctrl_t w;
    w.ready_en  = 1'b0;
    w.fetch     = 1'b0;
    w.update    = 1'b0;
    w.div_start = 1'b0;
    w.div_sel   = prtm_pkg::DIV_RESIDUAL;
    w.acc_op    = prtm_pkg::ACC_HOLD;
    w.emit      = 1'b0;
    w.cond      = prtm_pkg::COND_NEVER;
    w.target    = prtm_pkg::STEP_IDLE;
    unique case (step)
      prtm_pkg::STEP_IDLE: begin
        w.ready_en = 1'b1;
        w.cond     = prtm_pkg::COND_NO_ITEM;
        w.target   = prtm_pkg::STEP_IDLE;
      end
      prtm_pkg::STEP_FETCH: begin
        w.fetch  = 1'b1;
        w.cond   = prtm_pkg::COND_WRITE;
        w.target = prtm_pkg::STEP_WR_CHECK;
      end
      prtm_pkg::STEP_RANGE: begin
        w.cond   = prtm_pkg::COND_OUTSIDE;
        w.target = prtm_pkg::STEP_ZERO;
      end
      prtm_pkg::STEP_EMPTY: begin
        w.cond   = prtm_pkg::COND_CNT_ZERO;
        w.target = prtm_pkg::STEP_UNI_GO;
      end
      prtm_pkg::STEP_RES_GO: begin
        w.div_start = 1'b1;
        w.div_sel   = prtm_pkg::DIV_RESIDUAL;
      end
      prtm_pkg::STEP_RES_WAIT: begin
        w.cond   = prtm_pkg::COND_DIV_BUSY;
        w.target = prtm_pkg::STEP_RES_WAIT;
      end
      prtm_pkg::STEP_RES_TAKE: begin
        w.acc_op = prtm_pkg::ACC_LOAD;
        w.cond   = prtm_pkg::COND_BIT_CLEAR;
        w.target = prtm_pkg::STEP_EMIT;
      end
      prtm_pkg::STEP_LINK_GO: begin
        w.div_start = 1'b1;
        w.div_sel   = prtm_pkg::DIV_LINK;
      end
      prtm_pkg::STEP_LINK_WAIT: begin
        w.cond   = prtm_pkg::COND_DIV_BUSY;
        w.target = prtm_pkg::STEP_LINK_WAIT;
      end
      prtm_pkg::STEP_LINK_ADD: begin
        w.acc_op = prtm_pkg::ACC_ADD;
        w.cond   = prtm_pkg::COND_ALWAYS;
        w.target = prtm_pkg::STEP_EMIT;
      end
      prtm_pkg::STEP_UNI_GO: begin
        w.div_start = 1'b1;
        w.div_sel   = prtm_pkg::DIV_UNIFORM;
      end
      prtm_pkg::STEP_UNI_WAIT: begin
        w.cond   = prtm_pkg::COND_DIV_BUSY;
        w.target = prtm_pkg::STEP_UNI_WAIT;
      end
      prtm_pkg::STEP_UNI_TAKE: begin
        w.acc_op = prtm_pkg::ACC_LOAD;
        w.cond   = prtm_pkg::COND_ALWAYS;
        w.target = prtm_pkg::STEP_EMIT;
      end
      prtm_pkg::STEP_ZERO: begin
        w.acc_op = prtm_pkg::ACC_ZERO;
      end
      prtm_pkg::STEP_EMIT: begin
        w.emit   = 1'b1;
        w.cond   = prtm_pkg::COND_OUT_FULL;
        w.target = prtm_pkg::STEP_EMIT;
      end
      prtm_pkg::STEP_DONE: begin
        w.cond   = prtm_pkg::COND_ALWAYS;
        w.target = prtm_pkg::STEP_IDLE;
      end
      prtm_pkg::STEP_WR_CHECK: begin
        w.cond   = prtm_pkg::COND_OUTSIDE;
        w.target = prtm_pkg::STEP_IDLE;
      end
      prtm_pkg::STEP_UPDATE: begin
        w.update = 1'b1;
        w.cond   = prtm_pkg::COND_ALWAYS;
        w.target = prtm_pkg::STEP_IDLE;
      end
      default: begin
        w.cond   = prtm_pkg::COND_ALWAYS;
        w.target = prtm_pkg::STEP_IDLE;
      end
    endcase
    return w;
  endfunction

  logic [prtm_pkg::STEP_W-1:0] pc;
  logic [prtm_pkg::STEP_W-1:0] pc_next;
  logic                        take;

  assign ctrl = rom_word(pc);

  always_comb begin
    case (ctrl.cond)
      prtm_pkg::COND_NEVER:     take = 1'b0;
      prtm_pkg::COND_ALWAYS:    take = 1'b1;
      prtm_pkg::COND_NO_ITEM:   take = status.no_item;
      prtm_pkg::COND_WRITE:     take = status.write_op;
      prtm_pkg::COND_OUTSIDE:   take = status.outside;
      prtm_pkg::COND_CNT_ZERO:  take = status.cnt_zero;
      prtm_pkg::COND_DIV_BUSY:  take = status.div_busy;
      prtm_pkg::COND_BIT_CLEAR: take = status.bit_clear;
      prtm_pkg::COND_OUT_FULL:  take = status.out_full;
      default:                  take = 1'b0;
    endcase
    pc_next = take ? ctrl.target : pc + prtm_pkg::STEP_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= prtm_pkg::STEP_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (pc == prtm_pkg::STEP_IDLE && !status.no_item) |=> pc == prtm_pkg::STEP_FETCH)
    else $error("accepted item not fetched");

endmodule

FILE: sv/prtm_datapath.sv
// ----------------------------------------------------------------------------
// prtm_datapath
// Link rows, column counts, configuration, divider operand select, element
// accumulator and output register; all but the configuration are driven by the
// microcode word.
module prtm_datapath #(
  parameter int MAX_NODES = prtm_pkg::MAX_NODES_DEFAULT,
  parameter int DEN_W     = prtm_pkg::NODE_W
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [prtm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [prtm_pkg::CFG_DATA_W-1:0] cfg_data,
  prtm_req_if.sink                        req,
  prtm_rsp_if.source                      rsp,
  input  prtm_pkg::ctrl_t                 ctrl,
  output prtm_pkg::status_t               status,
  input  logic                            div_busy,
  input  logic [prtm_pkg::Q_W-1:0]        quotient,
  output logic [prtm_pkg::Q_W-1:0]        div_num,
  output logic [DEN_W-1:0]                div_den
);

  localparam int IDX_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CNT_W = $clog2(MAX_NODES + 1);

  logic [MAX_NODES-1:0] link_mem [MAX_NODES];
  logic [CNT_W-1:0]     cnt_mem  [MAX_NODES];

  logic [prtm_pkg::Q_W-1:0]      damping;
  logic [prtm_pkg::NODE_W-1:0]   node_count;
  logic                          clear_busy;
  logic [IDX_W-1:0]              clr_idx;
  logic                          op;
  logic [prtm_pkg::IDX_IN_W-1:0] row;
  logic [prtm_pkg::IDX_IN_W-1:0] column;
  logic                          link_bit;
  logic [MAX_NODES-1:0]          row_rd;
  logic [CNT_W-1:0]              cnt_rd;
  logic [prtm_pkg::Q_W-1:0]      acc;
  logic                          out_valid;
  logic [prtm_pkg::Q_W-1:0]      probability;

  logic [prtm_pkg::NODE_W-1:0] n_act;
  logic [prtm_pkg::Q_W-1:0]    d_act;
  logic [IDX_W-1:0]            row_idx;
  logic [IDX_W-1:0]            col_idx;
  logic                        accept;
  logic                        old_bit;
  logic                        changed;
  logic [MAX_NODES-1:0]        row_wr;
  logic [CNT_W-1:0]            cnt_wr;
  logic                        out_full;
  logic                        out_load;

  assign row_idx  = IDX_W'(row);
  assign col_idx  = IDX_W'(column);
  assign accept   = req.valid && req.ready;
  assign old_bit  = row_rd[col_idx];
  assign changed  = old_bit != link_bit;
  assign out_full = out_valid && !rsp.ready;
  assign out_load = ctrl.emit && !out_full;

  assign req.ready       = ctrl.ready_en && !clear_busy;
  assign rsp.valid       = out_valid;
  assign rsp.probability = probability;

  always_comb begin
    if (node_count == '0) begin
      n_act = prtm_pkg::NODE_W'(1);
    end else if (int'(node_count) > MAX_NODES) begin
      n_act = prtm_pkg::NODE_W'(MAX_NODES);
    end else begin
      n_act = node_count;
    end
    d_act = (damping > prtm_pkg::ONE_Q16) ? prtm_pkg::ONE_Q16 : damping;
  end

  always_comb begin
    status.no_item   = !accept;
    status.write_op  = op == prtm_pkg::OP_WRITE;
    status.outside   = !(({1'b0, row} < n_act) && ({1'b0, column} < n_act));
    status.cnt_zero  = cnt_rd == '0;
    status.div_busy  = div_busy;
    status.bit_clear = !old_bit;
    status.out_full  = out_full;
  end

  always_comb begin
    row_wr          = row_rd;
    row_wr[col_idx] = link_bit;
    cnt_wr          = link_bit ? cnt_rd + CNT_W'(1) : cnt_rd - CNT_W'(1);
  end

  always_comb begin
    case (ctrl.div_sel)
      prtm_pkg::DIV_RESIDUAL: begin
        div_num = prtm_pkg::ONE_Q16 - d_act;
        div_den = DEN_W'(n_act);
      end
      prtm_pkg::DIV_LINK: begin
        div_num = d_act;
        div_den = DEN_W'(cnt_rd);
      end
      default: begin
        div_num = prtm_pkg::ONE_Q16;
        div_den = DEN_W'(n_act);
      end
    endcase
  end

  // configuration and clearing sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      damping    <= prtm_pkg::DAMPING_RESET;
      node_count <= prtm_pkg::NODE_COUNT_RESET;
      clear_busy <= 1'b1;
      clr_idx    <= '0;
    end else begin
      if (clear_busy) begin
        if (clr_idx == IDX_W'(MAX_NODES - 1)) begin
          clear_busy <= 1'b0;
        end else begin
          clr_idx <= clr_idx + IDX_W'(1);
        end
      end
      if (cfg_write) begin
        unique case (cfg_index)
          prtm_pkg::CFG_DAMPING: begin
            damping <= cfg_data;
          end
          prtm_pkg::CFG_NODE_COUNT: begin
            node_count <= cfg_data[prtm_pkg::NODE_W-1:0];
            clear_busy <= 1'b1;
            clr_idx    <= '0;
          end
          default: begin
            damping <= damping;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clear_busy) begin
      link_mem[clr_idx] <= '0;
      cnt_mem[clr_idx]  <= '0;
    end else if (ctrl.update && changed) begin
      link_mem[row_idx] <= row_wr;
      cnt_mem[col_idx]  <= cnt_wr;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.fetch) begin
      row_rd <= link_mem[row_idx];
      cnt_rd <= cnt_mem[col_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op       <= req.operation;
      row      <= req.row;
      column   <= req.column;
      link_bit <= req.link_bit;
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.acc_op)
      prtm_pkg::ACC_ZERO: acc <= '0;
      prtm_pkg::ACC_LOAD: acc <= quotient;
      prtm_pkg::ACC_ADD:  acc <= acc + quotient;
      default:            acc <= acc;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      probability <= acc;
    end
  end

  assert property (@(posedge clk) disable iff (rst) clear_busy |-> !req.ready)
    else $error("item taken during clearing sweep");

  assert property (@(posedge clk) disable iff (rst)
    (cfg_write && cfg_index == prtm_pkg::CFG_NODE_COUNT) |=> clear_busy)
    else $error("node count write did not start clearing");

  assert property (@(posedge clk) disable iff (rst) ctrl.div_start |-> !div_busy)
    else $error("divider restarted while busy");

  assert property (@(posedge clk) disable iff (rst)
    out_load |=> probability <= prtm_pkg::ONE_Q16)
    else $error("element above one");

endmodule

FILE: sv/pagerank_transition_matrix.sv
// ----------------------------------------------------------------------------
// pagerank_transition_matrix
// Google transition matrix element unit over a 0/1 link matrix.
// ----------------------------------------------------------------------------
// Items are handled one at a time under a microcoded step sequencer. A link
// write updates one entry of the link matrix, and a write outside the active
// n by n matrix is dropped. A read outside the matrix yields zero, a read of
// a column with no links or of a clear entry needs one quotient, and a read
// of a set entry needs two: each quotient goes through one shared divider
// that produces one bit per cycle. After reset and after every node_count
// write a clearing sweep zeroes one link row and one column count per cycle
// over all MAX_NODES rows, during which no item is taken. Results sit in an
// output register, so the next item proceeds while the previous result waits
// to be taken.
module pagerank_transition_matrix #(
  parameter int MAX_NODES = prtm_pkg::MAX_NODES_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [prtm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [prtm_pkg::CFG_DATA_W-1:0] cfg_data,
  prtm_req_if.sink                        req,
  prtm_rsp_if.source                      rsp
);

  localparam int CNT_W = $clog2(MAX_NODES + 1);
  localparam int DEN_W = (CNT_W > prtm_pkg::NODE_W) ? CNT_W : prtm_pkg::NODE_W;

  prtm_pkg::ctrl_t          ctrl;
  prtm_pkg::status_t        status;
  logic                     div_busy;
  logic [prtm_pkg::Q_W-1:0] quotient;
  logic [prtm_pkg::Q_W-1:0] div_num;
  logic [DEN_W-1:0]         div_den;

  prtm_sequencer u_sequencer (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  prtm_divider #(
    .DEN_W (DEN_W)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (ctrl.div_start),
    .num      (div_num),
    .den      (div_den),
    .busy     (div_busy),
    .quotient (quotient)
  );

  prtm_datapath #(
    .MAX_NODES (MAX_NODES),
    .DEN_W     (DEN_W)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .rsp       (rsp),
    .ctrl      (ctrl),
    .status    (status),
    .div_busy  (div_busy),
    .quotient  (quotient),
    .div_num   (div_num),
    .div_den   (div_den)
  );

endmodule

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the transition matrix element unit. A directed plan
// covers empty columns, set and clear entries, damping at zero, one and above
// one, node counts of zero, in range and past the maximum, and accesses outside
// the active matrix. Random phases with fresh register settings follow. Every
// read is predicted from a local copy of the link matrix and column counts, or
// taken from the plan, and checked in order, with random gaps on the request
// side and stalls on the response side.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          NODES_MAX     = prtm_pkg::MAX_NODES_DEFAULT;
  localparam int          SETTLE_CYCLES = 64;
  localparam int          CYCLE_LIMIT   = 1000000;
  localparam int          PHASES        = 6;
  localparam int          PHASE_ITEMS   = 300;
  localparam int unsigned ONE           = 65536;

  typedef enum logic {ROW_ITEM, ROW_CFG} step_kind_t;

  typedef struct {
    step_kind_t                      kind;
    prtm_pkg::op_t                   op;
    logic [3:0]                      r;
    logic [3:0]                      c;
    logic                            lv;
    bit                              known;
    logic [prtm_pkg::Q_W-1:0]        value;
    prtm_pkg::cfg_reg_t              cfg_sel;
    logic [prtm_pkg::CFG_DATA_W-1:0] cfg_val;
  } plan_row_t;

  logic                            clk = 1'b0;
  logic                            rst;
  logic                            cfg_write;
  logic [prtm_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [prtm_pkg::CFG_DATA_W-1:0] cfg_data;

  prtm_req_if req_ch();
  prtm_rsp_if rsp_ch();

  pagerank_transition_matrix uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  // local copy of the block state
  bit                          link_map [NODES_MAX][NODES_MAX];
  int unsigned                 col_links [NODES_MAX];
  logic [prtm_pkg::Q_W-1:0]    damp_reg;
  logic [prtm_pkg::NODE_W-1:0] nodes_reg;

  logic [prtm_pkg::Q_W-1:0] pending_probability [$];
  plan_row_t                plan [$];

  int errors        = 0;
  int reads_checked = 0;
  int writes_sent   = 0;
  int items_counted = 0;
  int cfg_writes    = 0;
  int send_calm     = 0;
  int cycles        = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("testbench: errors");
    $finish;
  end

  function automatic int unsigned nodes_in_use();
    int unsigned n;
    n = nodes_reg;
    if (n < 1) n = 1;
    if (n > NODES_MAX) n = NODES_MAX;
    return n;
  endfunction

  function automatic logic [prtm_pkg::Q_W-1:0] element_of(input logic [3:0] r,
                                                          input logic [3:0] c);
    int unsigned n;
    int unsigned d;
    int unsigned val;
    n = nodes_in_use();
    d = (damp_reg > ONE) ? ONE : damp_reg;
    if (r >= n || c >= n) return '0;
    if (col_links[c] == 0) begin
      val = ONE / n;
    end else begin
      val = (ONE - d) / n;
      if (link_map[r][c]) val += d / col_links[c];
    end
    return val[prtm_pkg::Q_W-1:0];
  endfunction

  function automatic void clear_links();
    foreach (link_map[i, j]) link_map[i][j] = 1'b0;
    foreach (col_links[i]) col_links[i] = 0;
  endfunction

  function automatic void note_error(input string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endfunction

  function automatic int gap_len();
    int roll;
    if (send_calm > 0) begin
      send_calm--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 2) begin
      send_calm = $urandom_range(40, 200);
      return 0;
    end
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic row_item(input prtm_pkg::op_t op, input logic [3:0] r,
                          input logic [3:0] c, input logic lv, input bit known = 1'b0,
                          input logic [prtm_pkg::Q_W-1:0] value = '0);
    plan_row_t p;
    p.kind    = ROW_ITEM;
    p.op      = op;
    p.r       = r;
    p.c       = c;
    p.lv      = lv;
    p.known   = known;
    p.value   = value;
    p.cfg_sel = prtm_pkg::CFG_DAMPING;
    p.cfg_val = '0;
    plan.push_back(p);
  endtask

  task automatic row_cfg(input prtm_pkg::cfg_reg_t sel,
                         input logic [prtm_pkg::CFG_DATA_W-1:0] val);
    plan_row_t p;
    p.kind    = ROW_CFG;
    p.op      = prtm_pkg::OP_WRITE;
    p.r       = '0;
    p.c       = '0;
    p.lv      = 1'b0;
    p.known   = 1'b0;
    p.value   = '0;
    p.cfg_sel = sel;
    p.cfg_val = val;
    plan.push_back(p);
  endtask

  task automatic send_item(input prtm_pkg::op_t op, input logic [3:0] r,
                           input logic [3:0] c, input logic lv, input bit known,
                           input logic [prtm_pkg::Q_W-1:0] value);
    int gap;
    int unsigned n;
    gap = gap_len();
    @(negedge clk);
    if (gap > 0) begin
      req_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid     = 1'b1;
    req_ch.operation = op;
    req_ch.row       = r;
    req_ch.column    = c;
    req_ch.link_bit  = lv;
    do @(posedge clk); while (!req_ch.ready);
    n = nodes_in_use();
    if (op == prtm_pkg::OP_READ) begin
      pending_probability.push_back(known ? value : element_of(r, c));
      items_counted++;
    end else begin
      writes_sent++;
      if (r < n && c < n) begin
        items_counted++;
        if (link_map[r][c] != lv) begin
          link_map[r][c] = lv;
          if (lv) col_links[c]++;
          else col_links[c]--;
        end
      end
    end
  endtask

  task automatic quiesce();
    @(negedge clk);
    req_ch.valid = 1'b0;
    while (pending_probability.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input prtm_pkg::cfg_reg_t sel,
                                input logic [prtm_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = sel;
    cfg_data  = val;
    @(posedge clk);
    if (sel == prtm_pkg::CFG_DAMPING) begin
      damp_reg = val;
    end else begin
      nodes_reg = val[prtm_pkg::NODE_W-1:0];
      clear_links();
    end
    cfg_writes++;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task automatic random_phase(input int ph);
    int unsigned                     n;
    int                              done;
    int                              roll;
    prtm_pkg::op_t                   op;
    logic [3:0]                      r;
    logic [3:0]                      c;
    logic [prtm_pkg::CFG_DATA_W-1:0] dv;
    logic [prtm_pkg::CFG_DATA_W-1:0] nv;
    roll = $urandom_range(0, 9);
    if (roll == 0) dv = '0;
    else if (roll == 1) dv = prtm_pkg::ONE_Q16;
    else if (roll == 2) dv = prtm_pkg::CFG_DATA_W'($urandom_range(ONE + 1, 131071));
    else dv = prtm_pkg::CFG_DATA_W'($urandom_range(0, ONE - 1));
    roll = $urandom_range(0, 9);
    if (ph == 0 || roll == 2) nv = 16;
    else if (roll == 0) nv = 0;
    else if (roll == 1) nv = prtm_pkg::CFG_DATA_W'($urandom_range(17, 31));
    else if (roll < 6) nv = prtm_pkg::CFG_DATA_W'($urandom_range(1, 4));
    else nv = prtm_pkg::CFG_DATA_W'($urandom_range(5, 15));
    if ($urandom_range(0, 1))
      nv[prtm_pkg::CFG_DATA_W-1:prtm_pkg::NODE_W] =
        (prtm_pkg::CFG_DATA_W - prtm_pkg::NODE_W)'($urandom);
    quiesce();
    write_register(prtm_pkg::CFG_DAMPING, dv);
    write_register(prtm_pkg::CFG_NODE_COUNT, nv);
    n = nodes_in_use();
    done = items_counted + PHASE_ITEMS;
    while (items_counted < done) begin
      op = ($urandom_range(0, 99) < 55) ? prtm_pkg::OP_WRITE : prtm_pkg::OP_READ;
      if ($urandom_range(0, 9) != 0) begin
        r = 4'($urandom_range(0, n - 1));
        c = 4'($urandom_range(0, n - 1));
      end else begin
        r = 4'($urandom_range(0, 15));
        c = 4'($urandom_range(0, 15));
      end
      send_item(op, r, c, ($urandom_range(0, 99) < 75), 1'b0, '0);
    end
  endtask

  // response side: random stalls with calm stretches
  initial begin
    int stall;
    int calm;
    int roll;
    stall = 0;
    calm  = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (calm > 0) begin
        calm--;
        rsp_ch.ready = 1'b1;
      end else if (stall > 0) begin
        stall--;
        rsp_ch.ready = 1'b0;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 2) begin
          calm = $urandom_range(50, 300);
          rsp_ch.ready = 1'b1;
        end else if (roll < 70) begin
          rsp_ch.ready = 1'b1;
        end else if (roll < 93) begin
          stall = $urandom_range(0, 2);
          rsp_ch.ready = 1'b0;
        end else begin
          stall = $urandom_range(8, 40);
          rsp_ch.ready = 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    logic [prtm_pkg::Q_W-1:0] want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_probability.size() == 0) begin
        note_error($sformatf("result %0d arrived with nothing pending", rsp_ch.probability));
      end else begin
        want = pending_probability.pop_front();
        reads_checked++;
        if (rsp_ch.probability !== want)
          note_error($sformatf("read %0d: probability expected %0d got %0d",
                               reads_checked, want, rsp_ch.probability));
      end
    end
  end

  initial begin
    rst              = 1'b1;
    cfg_write        = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    req_ch.valid     = 1'b0;
    req_ch.operation = prtm_pkg::OP_WRITE;
    req_ch.row       = '0;
    req_ch.column    = '0;
    req_ch.link_bit  = 1'b0;
    damp_reg         = prtm_pkg::DAMPING_RESET;
    nodes_reg        = prtm_pkg::NODE_COUNT_RESET;
    clear_links();

    // empty columns, set and clear entries, rewrite of an unchanged bit
    row_item(prtm_pkg::OP_READ, 0, 0, 0, 1'b1, 4096);
    row_item(prtm_pkg::OP_READ, 15, 15, 1, 1'b1, 4096);
    row_item(prtm_pkg::OP_WRITE, 15, 0, 1);
    row_item(prtm_pkg::OP_READ, 15, 0, 0);
    row_item(prtm_pkg::OP_READ, 0, 0, 0);
    row_item(prtm_pkg::OP_WRITE, 15, 0, 1);
    row_item(prtm_pkg::OP_WRITE, 0, 0, 1);
    row_item(prtm_pkg::OP_READ, 15, 0, 0);
    row_item(prtm_pkg::OP_WRITE, 15, 0, 0);
    row_item(prtm_pkg::OP_READ, 0, 0, 0);
    // damping at one, above one, and zero
    row_cfg(prtm_pkg::CFG_DAMPING, prtm_pkg::ONE_Q16);
    row_item(prtm_pkg::OP_READ, 0, 0, 0);
    row_item(prtm_pkg::OP_READ, 1, 0, 0);
    row_cfg(prtm_pkg::CFG_DAMPING, 17'h1ffff);
    row_item(prtm_pkg::OP_READ, 0, 0, 0);
    row_cfg(prtm_pkg::CFG_DAMPING, 0);
    row_item(prtm_pkg::OP_READ, 0, 0, 0);
    // node count of zero, access outside the matrix
    row_cfg(prtm_pkg::CFG_NODE_COUNT, 0);
    row_item(prtm_pkg::OP_READ, 0, 0, 0, 1'b1, prtm_pkg::ONE_Q16);
    row_item(prtm_pkg::OP_READ, 1, 0, 0, 1'b1, 0);
    row_item(prtm_pkg::OP_WRITE, 0, 0, 1);
    row_item(prtm_pkg::OP_READ, 0, 0, 0);
    row_item(prtm_pkg::OP_WRITE, 3, 3, 1);
    row_item(prtm_pkg::OP_READ, 0, 3, 0, 1'b1, 0);
    // node count past the maximum
    row_cfg(prtm_pkg::CFG_NODE_COUNT, 31);
    row_item(prtm_pkg::OP_READ, 15, 15, 0, 1'b1, 4096);
    row_cfg(prtm_pkg::CFG_DAMPING, prtm_pkg::DAMPING_RESET);
    row_cfg(prtm_pkg::CFG_NODE_COUNT, 3);
    row_item(prtm_pkg::OP_WRITE, 2, 1, 1);
    row_item(prtm_pkg::OP_WRITE, 0, 1, 1);
    row_item(prtm_pkg::OP_READ, 2, 1, 0);
    row_item(prtm_pkg::OP_READ, 1, 1, 0);
    row_item(prtm_pkg::OP_READ, 3, 0, 0, 1'b1, 0);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        quiesce();
        write_register(plan[i].cfg_sel, plan[i].cfg_val);
      end else begin
        send_item(plan[i].op, plan[i].r, plan[i].c, plan[i].lv,
                  plan[i].known, plan[i].value);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) random_phase(ph);

    @(negedge clk);
    req_ch.valid = 1'b0;
    quiesce();
    if (pending_probability.size() != 0)
      note_error($sformatf("%0d reads never answered", pending_probability.size()));

    $display("covered %0d counted items: %0d reads checked, %0d link writes",
             items_counted, reads_checked, writes_sent);
    $display("%0d register writes over %0d random phases, %0d errors",
             cfg_writes, PHASES, errors);
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

FILE: pagerank_transition_matrix.f
sv/prtm_pkg.sv
sv/prtm_req_if.sv
sv/prtm_rsp_if.sv
sv/prtm_divider.sv
sv/prtm_sequencer.sv
sv/prtm_datapath.sv
sv/pagerank_transition_matrix.sv
sim/testbench.sv
